@@ hw/rtl/cdd_pkg.sv @@
// Shared types, widths, constants and month table for the date difference core.
`timescale 1ns / 1ps

package cdd_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned DIFF_W  = 24;
   localparam int unsigned DOY_W   = 9;
   localparam int unsigned WD_W    = 3;
   // Day count plus five; always positive and below 2**23.
   localparam int unsigned LIN_W   = 23;
   // Centuries, ceil(year / 100) up to 164.
   localparam int unsigned CENT_W  = 8;
   // ceil(year / 4) up to 4096.
   localparam int unsigned QUAD_W  = 13;
   localparam int unsigned PROD_W  = 27;
   localparam int unsigned REM_W   = 7;
   // Register stages from the request side to the response register.
   localparam int unsigned PIPE_DEPTH = 4;

   localparam logic [YEAR_W-1:0]  MAX_YEAR_VALUE = 14'd16383;
   // floor(year / 100) == (year * 5243) >> 19 for every 14-bit year.
   localparam logic [PROD_W-1:0]  RECIP_100      = 27'd5243;
   localparam int unsigned        RECIP_SHIFT    = 19;
   localparam logic [YEAR_W:0]    CENTURY_DAYS   = 15'd100;
   localparam logic [LIN_W-1:0]   DAYS_PER_YEAR  = 23'd365;
   // The day count minus one (epoch is day zero) plus five for the weekday offset.
   localparam logic [LIN_W-1:0]   LIN_BIAS       = 23'd4;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [YEAR_W-1:0]  year_a;
      logic [MONTH_W-1:0] month_a;
      logic [DAY_W-1:0]   day_a;
      logic [YEAR_W-1:0]  year_b;
      logic [MONTH_W-1:0] month_b;
      logic [DAY_W-1:0]   day_b;
   } req_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] day_difference;
      logic [DOY_W-1:0]         day_of_year;
      logic [WD_W-1:0]          weekday;
   } rsp_type;

   typedef struct packed {
      logic [LIN_W-1:0] lin_day;
      logic [DOY_W-1:0] day_of_year;
   } count_type;

   // Days in the year before the first of the given month.
   function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
      logic [DOY_W-1:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

@@ hw/rtl/cdd_interfaces.sv @@
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps

interface cdd_req_if;
   import cdd_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cdd_rsp_if;
   import cdd_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/cdd_day_count.sv @@
// Three-stage pipeline turning one date into its shifted linear day count and day of year.
`timescale 1ns / 1ps

module cdd_day_count (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [cdd_pkg::YEAR_W-1:0]  year,
   input  logic [cdd_pkg::MONTH_W-1:0] month,
   input  logic [cdd_pkg::DAY_W-1:0]   day,
   output cdd_pkg::count_type          count
);
   import cdd_pkg::*;

   // Stage 1: clamp and estimate floor(year / 100).
   logic [YEAR_W-1:0]  year_cl;
   logic [MONTH_W-1:0] month_cl;
   logic [PROD_W-1:0]  recip_prod;
   logic [YEAR_W-1:0]  s1_year_ff,  s1_year_in;
   logic [MONTH_W-1:0] s1_month_ff, s1_month_in;
   logic [DAY_W-1:0]   s1_day_ff,   s1_day_in;
   logic [CENT_W-1:0]  s1_cent_ff,  s1_cent_in;

   always_comb begin
      year_cl = (year > MAX_YEAR_VALUE) ? MAX_YEAR_VALUE : year;
      if (month == '0) begin
         month_cl = MONTH_JAN;
      end else if (month > MONTH_DEC) begin
         month_cl = MONTH_DEC;
      end else begin
         month_cl = month;
      end
      recip_prod  = PROD_W'(year_cl) * RECIP_100;
      s1_year_in  = year_cl;
      s1_month_in = month_cl;
      s1_day_in   = day;
      s1_cent_in  = CENT_W'(recip_prod >> RECIP_SHIFT);
   end

   // Stage 2: leap test, ceil(year / 100), ceil(year / 4) and the day of year.
   logic [YEAR_W:0]    cent_prod;
   logic [YEAR_W:0]    rem_full;
   logic [REM_W-1:0]   rem100;
   logic               leap;
   logic [YEAR_W:0]    quad_sum;
   logic [YEAR_W-1:0]  s2_year_ff, s2_year_in;
   logic [QUAD_W-1:0]  s2_quad_ff, s2_quad_in;
   logic [CENT_W-1:0]  s2_cent_ff, s2_cent_in;
   logic [DOY_W-1:0]   s2_doy_ff,  s2_doy_in;

   always_comb begin
      cent_prod  = (YEAR_W+1)'(s1_cent_ff) * CENTURY_DAYS;
      rem_full   = {1'b0, s1_year_ff} - cent_prod;
      rem100     = rem_full[REM_W-1:0];
      // A century year is a leap year only when its century count is a multiple of four.
      leap       = (s1_year_ff[1:0] == 2'b00) &&
                   ((rem100 != '0) || (s1_cent_ff[1:0] == 2'b00));
      quad_sum   = {1'b0, s1_year_ff} + (YEAR_W+1)'(3);
      s2_year_in = s1_year_ff;
      s2_quad_in = quad_sum[QUAD_W+1:2];
      s2_cent_in = s1_cent_ff + CENT_W'(rem100 != '0);
      s2_doy_in  = days_before_month(s1_month_ff) + DOY_W'(s1_day_ff)
                 + DOY_W'((s1_month_ff > MONTH_FEB) && leap);
   end

   // Stage 3: sum the year days, leap days and day of year.
   logic [LIN_W-1:0]  year_days;
   logic [CENT_W:0]   quad_cent_sum;
   logic [CENT_W-2:0] cent400;
   logic [LIN_W-1:0]  s3_lin_ff, s3_lin_in;
   logic [DOY_W-1:0]  s3_doy_ff, s3_doy_in;

   always_comb begin
      year_days     = LIN_W'(s2_year_ff) * DAYS_PER_YEAR;
      quad_cent_sum = {1'b0, s2_cent_ff} + (CENT_W+1)'(3);
      cent400       = quad_cent_sum[CENT_W:2];
      // ceil(year / 4) never falls below ceil(year / 100), so the sum stays positive.
      s3_lin_in     = year_days + LIN_W'(s2_quad_ff) - LIN_W'(s2_cent_ff)
                    + LIN_W'(cent400) + LIN_W'(s2_doy_ff) + LIN_BIAS;
      s3_doy_in     = s2_doy_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_year_ff  <= s1_year_in;
         s1_month_ff <= s1_month_in;
         s1_day_ff   <= s1_day_in;
         s1_cent_ff  <= s1_cent_in;
         s2_year_ff  <= s2_year_in;
         s2_quad_ff  <= s2_quad_in;
         s2_cent_ff  <= s2_cent_in;
         s2_doy_ff   <= s2_doy_in;
         s3_lin_ff   <= s3_lin_in;
         s3_doy_ff   <= s3_doy_in;
      end
   end

   assign count.lin_day     = s3_lin_ff;
   assign count.day_of_year = s3_doy_ff;

endmodule

@@ hw/rtl/cdd_finish.sv @@
// Final stage: signed difference of the day counts; day of year and weekday of A.
`timescale 1ns / 1ps

module cdd_finish (
   input  logic               clock,
   input  logic               advance,
   input  cdd_pkg::count_type count_a,
   input  cdd_pkg::count_type count_b,
   output cdd_pkg::rsp_type   result
);
   import cdd_pkg::*;

   localparam int unsigned CHUNKS = (LIN_W + 2) / 3;

   logic [3*CHUNKS-1:0] lin_pad;
   logic [5:0]          chunk_sum;
   logic [3:0]          fold1;
   logic [2:0]          fold2;
   logic [WD_W-1:0]     mod7;
   rsp_type             result_ff, result_in;

   always_comb begin
      lin_pad   = (3*CHUNKS)'(count_a.lin_day);
      // Eight is one modulo seven, so octal digits add up to the same residue.
      chunk_sum = '0;
      for (int i = 0; i < CHUNKS; i++) begin
         chunk_sum = chunk_sum + 6'(lin_pad[3*i +: 3]);
      end
      fold1 = 4'(chunk_sum[5:3]) + 4'(chunk_sum[2:0]);
      fold2 = 3'(fold1[3]) + fold1[2:0];
      mod7  = (fold2 == 3'd7) ? 3'd0 : fold2;

      result_in.day_difference = $signed({1'b0, count_a.lin_day} - {1'b0, count_b.lin_day});
      result_in.day_of_year    = count_a.day_of_year;
      result_in.weekday        = mod7 + WD_W'(1);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

@@ hw/rtl/calendar_date_difference_core.sv @@
// Top level of the calendar date difference core: four-stage pipeline and handshake.
`timescale 1ns / 1ps

// Each request beat carries two proleptic Gregorian dates A and B (year, month, day); the
// response beat gives the signed number of days from B to A, the day of the year of A and
// the weekday of A (1 is Monday, 7 is Sunday). Months outside 1..12 are clamped to January
// or December, and a day of zero or past the month end simply adds to the days before its
// month. The pipeline is four register stages deep: a request beat passes through stage 1,
// stage 2, stage 3 and the response register on its way to the response side, and while
// the sink does not hold the response beat, a new beat is taken in every cycle. The longest
// stage multiplies the year by 365 and sums the leap-day terms. All stages advance
// together; when the response beat is held by the sink the whole pipeline waits, so
// nothing is dropped or repeated. The core keeps no state across beats beyond its pipeline.
module calendar_date_difference_core (
   input logic       clock,
   input logic       reset,
   cdd_req_if.sink   req_ch,
   cdd_rsp_if.source rsp_ch
);
   import cdd_pkg::*;

   logic [PIPE_DEPTH-1:0] pipe_valid_ff, pipe_valid_in;
   logic                  advance;
   count_type             count_a;
   count_type             count_b;
   rsp_type               result;

   // The pipeline moves whenever its last stage is empty or being drained this cycle.
   assign advance      = !pipe_valid_ff[PIPE_DEPTH-1] || rsp_ch.ready;
   assign req_ch.ready = advance;

   assign pipe_valid_in = {pipe_valid_ff[PIPE_DEPTH-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
      end else if (advance) begin
         pipe_valid_ff <= pipe_valid_in;
      end
   end

   // Dates A and B run through identical day-count pipelines side by side.
   cdd_day_count u_count_a (
      .clock   (clock),
      .advance (advance),
      .year    (req_ch.data.year_a),
      .month   (req_ch.data.month_a),
      .day     (req_ch.data.day_a),
      .count   (count_a)
   );

   cdd_day_count u_count_b (
      .clock   (clock),
      .advance (advance),
      .year    (req_ch.data.year_b),
      .month   (req_ch.data.month_b),
      .day     (req_ch.data.day_b),
      .count   (count_b)
   );

   cdd_finish u_finish (
      .clock   (clock),
      .advance (advance),
      .count_a (count_a),
      .count_b (count_b),
      .result  (result)
   );

   assign rsp_ch.valid = pipe_valid_ff[PIPE_DEPTH-1];
   assign rsp_ch.data  = result;

   // A stalled pipeline must keep every valid bit where it is.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pipe_valid_ff))
      else $error("pipeline valid bits moved during a stall");

   // The weekday of a delivered beat is always Monday through Sunday.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.data.weekday != '0))
      else $error("weekday out of range");

   // Clamped months and five-bit days keep the day of year at or below 366.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.data.day_of_year <= DOY_W'(366)))
      else $error("day of year out of range");

endmodule
